// ----- hdl/sadst_pkg.sv -----
// package for the shared array double stack
// holds the operation and status codes and the payload structs
// no dependencies
package sadst_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned WordWidth    = 32;

  typedef enum logic [1:0] {
    MODE_PUSH_LOW  = 2'd0,
    MODE_PUSH_HIGH = 2'd1,
    MODE_POP_LOW   = 2'd2,
    MODE_POP_HIGH  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    mode_e                        mode;
    logic signed [WordWidth-1:0]  push_value;
  } in_t;

  typedef struct packed {
    status_e                      status;
    logic signed [WordWidth-1:0]  popped_value;
    logic                         store_full;
    logic                         both_empty;
  } out_t;

  // classified operation handed from front to back
  typedef struct packed {
    logic    wr;
    logic    rd;
    status_e status;
    logic    store_full;
    logic    both_empty;
  } ctrl_t;

endpackage

// ----- hdl/sadst_ram.sv -----
// generic single write port, single read port ram with registered read
// depends on nothing
module sadst_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/sadst_front.sv -----
// front end: accepts operations, tracks both stack counts, classifies each
// operation and forms the store address; depends on sadst_pkg
module sadst_front #(
  parameter int unsigned Depth = sadst_pkg::DefaultDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CntW  = $clog2(Depth + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  sadst_pkg::in_t                    cmd_i,
  input  logic                              q_full_i,
  output logic                              busy_o,
  output logic                              push_o,
  output sadst_pkg::ctrl_t                  ctrl_o,
  output logic [AddrW-1:0]                  addr_o,
  output logic [sadst_pkg::WordWidth-1:0]   data_o
);

  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW:0]    DepthSum = (CntW + 1)'(Depth);

  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CntW-1:0] lo_dec, hi_dec;
  logic [CntW:0]   sum_now, sum_next;
  logic            full_now, accept;

  assign busy_o  = q_full_i;
  assign accept  = start_i && !q_full_i;
  assign lo_dec  = lo_q - CntW'(1);
  assign hi_dec  = hi_q - CntW'(1);
  assign sum_now = {1'b0, lo_q} + {1'b0, hi_q};
  assign full_now = (sum_now >= DepthSum);

  always_comb begin
    lo_d          = lo_q;
    hi_d          = hi_q;
    ctrl_o        = '0;
    ctrl_o.status = sadst_pkg::ST_DONE;
    addr_o        = '0;
    data_o        = cmd_i.push_value;
    case (cmd_i.mode)
      sadst_pkg::MODE_PUSH_LOW: begin
        if (full_now) begin
          ctrl_o.status = sadst_pkg::ST_FULL;
        end else begin
          ctrl_o.wr = 1'b1;
          addr_o    = lo_q[AddrW-1:0];
          lo_d      = lo_q + CntW'(1);
        end
      end
      sadst_pkg::MODE_PUSH_HIGH: begin
        if (full_now) begin
          ctrl_o.status = sadst_pkg::ST_FULL;
        end else begin
          ctrl_o.wr = 1'b1;
          addr_o    = LastAddr - hi_q[AddrW-1:0];
          hi_d      = hi_q + CntW'(1);
        end
      end
      sadst_pkg::MODE_POP_LOW: begin
        if (lo_q == '0) begin
          ctrl_o.status = sadst_pkg::ST_EMPTY;
        end else begin
          ctrl_o.rd = 1'b1;
          addr_o    = lo_dec[AddrW-1:0];
          lo_d      = lo_dec;
        end
      end
      default: begin
        if (hi_q == '0) begin
          ctrl_o.status = sadst_pkg::ST_EMPTY;
        end else begin
          ctrl_o.rd = 1'b1;
          addr_o    = LastAddr - hi_dec[AddrW-1:0];
          hi_d      = hi_dec;
        end
      end
    endcase
    sum_next          = {1'b0, lo_d} + {1'b0, hi_d};
    ctrl_o.store_full = (sum_next >= DepthSum);
    ctrl_o.both_empty = (lo_d == '0) && (hi_d == '0);
  end

  assign push_o = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q <= '0;
      hi_q <= '0;
    end else if (accept) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
    end
  end

endmodule

// ----- hdl/sadst_queue.sv -----
// short fifo between front and back ends
// depends on nothing
module sadst_queue #(
  parameter int unsigned Width   = 8,
  parameter int unsigned Entries = 2,
  localparam int unsigned PtrW = (Entries > 1) ? $clog2(Entries) : 1,
  localparam int unsigned CntW = $clog2(Entries + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             valid_o,
  output logic             full_o
);

  localparam logic [PtrW-1:0] LastPtr = PtrW'(Entries - 1);
  localparam logic [CntW-1:0] MaxCnt  = CntW'(Entries);

  logic [Width-1:0] slot_q [Entries];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == MaxCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

// ----- hdl/sadst_back.sv -----
// back end: drains the queue, drives the store and forms the results
// depends on sadst_pkg and sadst_ram
module sadst_back #(
  parameter int unsigned Depth = sadst_pkg::DefaultDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  sadst_pkg::ctrl_t                 ctrl_i,
  input  logic [AddrW-1:0]                 addr_i,
  input  logic [sadst_pkg::WordWidth-1:0]  data_i,
  output logic                             pop_o,
  output logic                             done_o,
  output sadst_pkg::out_t                  result_o
);

  logic [sadst_pkg::WordWidth-1:0] rdata;
  sadst_pkg::ctrl_t                ctrl_q;
  logic                            valid_q;

  // results cannot be held off, so every queued operation goes at once
  assign pop_o = q_valid_i;

  sadst_ram #(
    .Width (sadst_pkg::WordWidth),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (q_valid_i && ctrl_i.wr),
    .waddr_i (addr_i),
    .wdata_i (data_i),
    .re_i    (q_valid_i && ctrl_i.rd),
    .raddr_i (addr_i),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_valid_i) begin
      ctrl_q <= ctrl_i;
    end
  end

  assign done_o                = valid_q;
  assign result_o.status       = ctrl_q.status;
  assign result_o.popped_value = ctrl_q.rd ? rdata : '0;
  assign result_o.store_full   = ctrl_q.store_full;
  assign result_o.both_empty   = ctrl_q.both_empty;

endmodule

// ----- hdl/shared_array_double_stack.sv -----
// two stacks in one store: stack one grows up from entry 0, stack two down
// from the last entry. a result strobes on done_o after the queue slot, then
// the read and result registers; throughput one operation per cycle while
// busy_o is low, each using one store port at most once. busy_o rises only
// if the front/back queue fills. reset clears both counts and the queue at
// once; the store is not cleared, entries are read only after being written.
module shared_array_double_stack #(
  parameter int unsigned Depth = sadst_pkg::DefaultDepth,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  sadst_pkg::in_t   cmd_i,
  output logic             busy_o,
  output logic             done_o,
  output sadst_pkg::out_t  result_o
);

  localparam int unsigned QW = AddrW + sadst_pkg::WordWidth + $bits(sadst_pkg::ctrl_t);

  sadst_pkg::ctrl_t                f_ctrl, b_ctrl;
  logic [AddrW-1:0]                f_addr, b_addr;
  logic [sadst_pkg::WordWidth-1:0] f_data, b_data;
  logic                            f_push, q_full, q_valid, b_pop;
  logic [QW-1:0]                   q_in, q_out;

  sadst_front #(
    .Depth (Depth)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .busy_o   (busy_o),
    .push_o   (f_push),
    .ctrl_o   (f_ctrl),
    .addr_o   (f_addr),
    .data_o   (f_data)
  );

  assign q_in = {f_addr, f_data, f_ctrl};

  sadst_queue #(
    .Width   (QW),
    .Entries (sadst_pkg::QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_in),
    .pop_i   (b_pop),
    .data_o  (q_out),
    .valid_o (q_valid),
    .full_o  (q_full)
  );

  assign {b_addr, b_data, b_ctrl} = q_out;

  sadst_back #(
    .Depth (Depth)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .ctrl_i    (b_ctrl),
    .addr_i    (b_addr),
    .data_i    (b_data),
    .pop_o     (b_pop),
    .done_o    (done_o),
    .result_o  (result_o)
  );

endmodule

// ----- hdl/sadst_checker.sv -----
// port level checks for shared_array_double_stack, attached by bind
// depends on sadst_pkg
module sadst_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            busy_o,
  input  logic            done_o,
  input  sadst_pkg::out_t result_o
);

  // every transfer is followed by its result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result missing two cycles after transfer");

  // no result without a transfer behind it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 2))
    else $error("result without transfer");

  // refused operations report a zero word
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != sadst_pkg::ST_DONE) |-> result_o.popped_value == '0)
    else $error("refused operation returned a word");

  // a refused push leaves the store full
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == sadst_pkg::ST_FULL) |-> result_o.store_full)
    else $error("full refusal without full flag");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(result_o.store_full && result_o.both_empty))
    else $error("store both full and empty");

endmodule

bind shared_array_double_stack sadst_checker u_sadst_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start_i  (start_i),
  .busy_o   (busy_o),
  .done_o   (done_o),
  .result_o (result_o)
);
